// File: rtl/ueq_pkg.sv
`default_nettype none
package ueq_pkg;

  localparam int unsigned CAPACITY     = 8;
  localparam int unsigned TIME_BITS    = 40;
  localparam int unsigned TAG_BITS     = 16;
  localparam int unsigned RESULT_LIMIT = 8;
  localparam int unsigned MC_W         = 4;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // input word layout
  localparam int unsigned IN_START_LO = 0;
  localparam int unsigned IN_END_LO   = IN_START_LO + TIME_BITS;
  localparam int unsigned IN_TAG_LO   = IN_END_LO + TIME_BITS;
  localparam int unsigned IN_FROM_LO  = IN_TAG_LO + TAG_BITS;
  localparam int unsigned IN_MAX_LO   = IN_FROM_LO + TIME_BITS;
  localparam int unsigned IN_FIELDS_W = IN_MAX_LO + MC_W;
  localparam int unsigned IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // output word layout
  localparam int unsigned OUT_FIELDS_W = 1 + 2 * TIME_BITS + TAG_BITS + MC_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    logic [TAG_BITS-1:0]  tag;
  } ueq_entry_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic pop;
  } ueq_cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/ueq_slot_store.sv
`default_nettype none
module ueq_slot_store (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire ueq_pkg::ueq_entry_t             wr_entry_i,
  input  wire logic [ueq_pkg::IDX_W-1:0]       rd_idx_i,
  output ueq_pkg::ueq_entry_t                  rd_entry_o,
  output logic [ueq_pkg::CNT_W-1:0]            used_o,
  output logic                                 full_o
);

  logic [ueq_pkg::TIME_BITS-1:0] start_q [ueq_pkg::CAPACITY];
  logic [ueq_pkg::TIME_BITS-1:0] end_q   [ueq_pkg::CAPACITY];
  logic [ueq_pkg::TAG_BITS-1:0]  tag_q   [ueq_pkg::CAPACITY];
  logic [ueq_pkg::CNT_W-1:0]     used_q, used_d;

  assign full_o = (used_q == ueq_pkg::CNT_W'(ueq_pkg::CAPACITY));
  assign used_o = used_q;
  assign used_d = used_q + ueq_pkg::CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_en_i && !full_o) begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !full_o) begin
      start_q[used_q[ueq_pkg::IDX_W-1:0]] <= wr_entry_i.start_time;
      end_q[used_q[ueq_pkg::IDX_W-1:0]]   <= wr_entry_i.end_time;
      tag_q[used_q[ueq_pkg::IDX_W-1:0]]   <= wr_entry_i.tag;
    end
  end

  always_comb begin
    rd_entry_o.valid      = 1'b1;
    rd_entry_o.start_time = start_q[rd_idx_i];
    rd_entry_o.end_time   = end_q[rd_idx_i];
    rd_entry_o.tag        = tag_q[rd_idx_i];
  end

endmodule
`default_nettype wire

// File: rtl/ueq_sort_cell.sv
`default_nettype none
module ueq_sort_cell (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ueq_pkg::ueq_cell_ctrl_t ctrl_i,
  input  wire ueq_pkg::ueq_entry_t    new_entry_i,
  input  wire ueq_pkg::ueq_entry_t    left_entry_i,
  input  wire logic                   left_gt_i,
  input  wire ueq_pkg::ueq_entry_t    right_entry_i,
  output ueq_pkg::ueq_entry_t         entry_o,
  output logic                        gt_o
);

  ueq_pkg::ueq_entry_t entry_q, entry_d;

  // new word belongs at or before this cell
  assign gt_o = !entry_q.valid ||
                ($signed(entry_q.start_time) > $signed(new_entry_i.start_time));
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.clear) begin
      entry_d.valid = 1'b0;
    end else if (ctrl_i.insert && gt_o) begin
      entry_d = left_gt_i ? left_entry_i : new_entry_i;
    end else if (ctrl_i.pop) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/upcoming_event_sorted_query.sv
// upcoming event table with sorted query
// input channel s_axis: tuser selects add (0) or query (1); tdata carries the
// event times and tag for an add, the reference time and limit for a query.
// output channel m_axis: one word per add (accepted flag), one word per kept
// event of a query in ascending start order, or one empty word; tlast marks
// the final word of each request, tuser marks a word that carries an event.
// an add's word appears in the output register the cycle after acceptance.
// a query scans the stored slots one per cycle through the row of sort cells,
// stopping early once the query limit of events is kept, then emits its words
// one per cycle while the receiver accepts them.
// one request is in flight at a time; tready drops while a query runs.
// reset empties the table and the output register.
// if the receiver stalls the output register holds its word and the emit
// sequence waits; no word is lost or repeated.
`default_nettype none
module upcoming_event_sorted_query (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // start_time, end_time, entry_tag, from_time, max_count
  input  wire logic [ueq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // req_type
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // accepted, start_time_out, end_time_out, tag_out, match_count
  output logic [ueq_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // has_event
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e                          state_q;
  logic [ueq_pkg::CNT_W-1:0]       idx_q;
  logic [ueq_pkg::MC_W-1:0]        n_q, rem_q, limit_q;
  logic [ueq_pkg::TIME_BITS-1:0]   from_q;

  logic                            out_acc_q, out_has_q, out_last_q;
  logic [ueq_pkg::TIME_BITS-1:0]   out_start_q, out_end_q;
  logic [ueq_pkg::TAG_BITS-1:0]    out_tag_q;
  logic [ueq_pkg::MC_W-1:0]        out_cnt_q;
  logic                            out_valid_q;

  logic                            in_fire, out_free, out_load, scan_go, hit;
  logic [ueq_pkg::MC_W-1:0]        in_max;
  ueq_pkg::ueq_entry_t             wr_entry, rd_entry;
  logic [ueq_pkg::CNT_W-1:0]       used;
  logic                            full;
  logic                            store_wr;
  ueq_pkg::ueq_cell_ctrl_t         cell_ctrl;

  ueq_pkg::ueq_entry_t             cell_entry [ueq_pkg::RESULT_LIMIT];
  logic                            cell_gt    [ueq_pkg::RESULT_LIMIT];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign in_max = s_axis_tdata[ueq_pkg::IN_MAX_LO +: ueq_pkg::MC_W];

  always_comb begin
    wr_entry.valid      = 1'b1;
    wr_entry.start_time = s_axis_tdata[ueq_pkg::IN_START_LO +: ueq_pkg::TIME_BITS];
    wr_entry.end_time   = s_axis_tdata[ueq_pkg::IN_END_LO +: ueq_pkg::TIME_BITS];
    wr_entry.tag        = s_axis_tdata[ueq_pkg::IN_TAG_LO +: ueq_pkg::TAG_BITS];
  end

  assign store_wr = in_fire && (s_axis_tuser == ueq_pkg::REQ_ADD);
  assign out_load = store_wr || ((state_q == ST_EMIT) && out_free);

  ueq_slot_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (store_wr),
    .wr_entry_i (wr_entry),
    .rd_idx_i   (idx_q[ueq_pkg::IDX_W-1:0]),
    .rd_entry_o (rd_entry),
    .used_o     (used),
    .full_o     (full)
  );

  assign scan_go = (state_q == ST_SCAN) && (idx_q < used) && (n_q < limit_q);
  assign hit     = scan_go && ($signed(rd_entry.end_time) > $signed(from_q));

  assign cell_ctrl.clear  = in_fire && (s_axis_tuser == ueq_pkg::REQ_QUERY);
  assign cell_ctrl.insert = hit;
  assign cell_ctrl.pop    = (state_q == ST_EMIT) && out_free && (n_q != '0);

  for (genvar i = 0; i < int'(ueq_pkg::RESULT_LIMIT); i++) begin : g_cell
    ueq_pkg::ueq_entry_t left_entry, right_entry;
    logic                left_gt;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == int'(ueq_pkg::RESULT_LIMIT) - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    ueq_sort_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .new_entry_i   (rd_entry),
      .left_entry_i  (left_entry),
      .left_gt_i     (left_gt),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[i]),
      .gt_o          (cell_gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      n_q         <= '0;
      rem_q       <= '0;
      limit_q     <= '0;
      from_q      <= '0;
      out_valid_q <= 1'b0;
      out_acc_q   <= 1'b0;
      out_has_q   <= 1'b0;
      out_last_q  <= 1'b0;
      out_start_q <= '0;
      out_end_q   <= '0;
      out_tag_q   <= '0;
      out_cnt_q   <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser == ueq_pkg::REQ_ADD) begin
              out_valid_q <= 1'b1;
              out_acc_q   <= !full;
              out_has_q   <= 1'b0;
              out_last_q  <= 1'b1;
              out_start_q <= '0;
              out_end_q   <= '0;
              out_tag_q   <= '0;
              out_cnt_q   <= '0;
            end else begin
              state_q <= ST_SCAN;
              idx_q   <= '0;
              n_q     <= '0;
              from_q  <= s_axis_tdata[ueq_pkg::IN_FROM_LO +: ueq_pkg::TIME_BITS];
              limit_q <= (in_max > ueq_pkg::MC_W'(ueq_pkg::RESULT_LIMIT)) ?
                         ueq_pkg::MC_W'(ueq_pkg::RESULT_LIMIT) : in_max;
            end
          end
        end
        ST_SCAN: begin
          if (scan_go) begin
            idx_q <= idx_q + ueq_pkg::CNT_W'(1);
            if (hit) begin
              n_q <= n_q + ueq_pkg::MC_W'(1);
            end
          end else begin
            state_q <= ST_EMIT;
            rem_q   <= n_q;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_acc_q   <= 1'b0;
            if (n_q == '0) begin
              out_has_q   <= 1'b0;
              out_last_q  <= 1'b1;
              out_start_q <= '0;
              out_end_q   <= '0;
              out_tag_q   <= '0;
              out_cnt_q   <= '0;
              state_q     <= ST_IDLE;
            end else begin
              out_has_q   <= 1'b1;
              out_last_q  <= (rem_q == ueq_pkg::MC_W'(1));
              out_start_q <= cell_entry[0].start_time;
              out_end_q   <= cell_entry[0].end_time;
              out_tag_q   <= cell_entry[0].tag;
              out_cnt_q   <= n_q;
              rem_q       <= rem_q - ueq_pkg::MC_W'(1);
              if (rem_q == ueq_pkg::MC_W'(1)) begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_has_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = ueq_pkg::OUT_DATA_W'({out_cnt_q, out_tag_q, out_end_q,
                                                out_start_q, out_acc_q});

endmodule
`default_nettype wire

// File: tb/upcoming_event_sorted_query_test.sv
`timescale 1ns / 1ps
module upcoming_event_sorted_query_test;
  import ueq_pkg::*;

  localparam int unsigned OUT_START_LO = 1;
  localparam int unsigned OUT_END_LO   = OUT_START_LO + TIME_BITS;
  localparam int unsigned OUT_TAG_LO   = OUT_END_LO + TIME_BITS;
  localparam int unsigned OUT_CNT_LO   = OUT_TAG_LO + TAG_BITS;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned TAIL_CYCLES  = 40;

  typedef logic signed [TIME_BITS-1:0] stime_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [MC_W-1:0] count_t;

  localparam stime_t T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam stime_t T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};

  typedef struct {
    logic   accepted;
    logic   has_event;
    stime_t start_time;
    stime_t end_time;
    tag_t   tag;
    count_t match_count;
    logic   last;
  } result_word_t;

  typedef struct {
    logic   req;
    stime_t start_time;
    stime_t end_time;
    tag_t   tag;
    stime_t from_time;
    count_t max_count;
    bit     typed;
    logic   want_accept;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  stime_t slot_start_q [CAPACITY];
  stime_t slot_end_q [CAPACITY];
  tag_t slot_tag_q [CAPACITY];
  int unsigned stored_count = 0;

  result_word_t pending_words [$];
  int unsigned error_count = 0;
  int unsigned words_checked = 0;
  int unsigned quiet_cycles = 0;
  bit steady = 1'b0;

  always #5 clk_i = ~clk_i;

  upcoming_event_sorted_query dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic result_word_t blank_word();
    result_word_t w;
    w.accepted    = 1'b0;
    w.has_event   = 1'b0;
    w.start_time  = '0;
    w.end_time    = '0;
    w.tag         = '0;
    w.match_count = '0;
    w.last        = 1'b1;
    return w;
  endfunction

  function automatic request_t add_row(stime_t s, stime_t e, tag_t t, bit typed, logic acc);
    request_t r;
    r.req         = REQ_ADD;
    r.start_time  = s;
    r.end_time    = e;
    r.tag         = t;
    r.from_time   = '0;
    r.max_count   = '0;
    r.typed       = typed;
    r.want_accept = acc;
    return r;
  endfunction

  function automatic request_t query_row(stime_t f, count_t m, bit typed);
    request_t r;
    r.req         = REQ_QUERY;
    r.start_time  = '0;
    r.end_time    = '0;
    r.tag         = '0;
    r.from_time   = f;
    r.max_count   = m;
    r.typed       = typed;
    r.want_accept = 1'b0;
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_request(request_t r);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[IN_START_LO +: TIME_BITS] = r.start_time;
    d[IN_END_LO +: TIME_BITS]   = r.end_time;
    d[IN_TAG_LO +: TAG_BITS]    = r.tag;
    d[IN_FROM_LO +: TIME_BITS]  = r.from_time;
    d[IN_MAX_LO +: MC_W]        = r.max_count;
    return d;
  endfunction

  // table update and sorted upcoming-event list for one request
  task automatic predict_request(input request_t r, ref result_word_t words [$]);
    int unsigned order [RESULT_LIMIT];
    int unsigned limit;
    int unsigned n;
    int unsigned pos;
    result_word_t w;
    words.delete();
    w = blank_word();
    if (r.req == REQ_ADD) begin
      if (stored_count < CAPACITY) begin
        slot_start_q[stored_count] = r.start_time;
        slot_end_q[stored_count]   = r.end_time;
        slot_tag_q[stored_count]   = r.tag;
        stored_count++;
        w.accepted = 1'b1;
      end
      words.push_back(w);
    end else begin
      limit = (r.max_count > RESULT_LIMIT) ? RESULT_LIMIT : r.max_count;
      n = 0;
      for (int i = 0; i < stored_count && n < limit; i++) begin
        if (slot_end_q[i] > r.from_time) begin
          pos = n;
          while (pos > 0 && slot_start_q[order[pos-1]] > slot_start_q[i]) begin
            order[pos] = order[pos-1];
            pos--;
          end
          order[pos] = i;
          n++;
        end
      end
      if (n == 0) begin
        words.push_back(w);
      end else begin
        for (int k = 0; k < n; k++) begin
          w.has_event   = 1'b1;
          w.start_time  = slot_start_q[order[k]];
          w.end_time    = slot_end_q[order[k]];
          w.tag         = slot_tag_q[order[k]];
          w.match_count = count_t'(n);
          w.last        = (k + 1 == n);
          words.push_back(w);
        end
      end
    end
  endtask

  task automatic drive_word(input request_t r);
    while (!steady && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_request(r);
    s_axis_tuser  <= r.req;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : output_check
    result_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        error_count++;
        $error("output word with nothing expected");
      end else begin
        want = pending_words.pop_front();
        check_field("accepted", want.accepted, m_axis_tdata[0]);
        check_field("has_event", want.has_event, m_axis_tuser);
        check_field("start_time_out", want.start_time,
                    stime_t'(m_axis_tdata[OUT_START_LO +: TIME_BITS]));
        check_field("end_time_out", want.end_time,
                    stime_t'(m_axis_tdata[OUT_END_LO +: TIME_BITS]));
        check_field("tag_out", want.tag, m_axis_tdata[OUT_TAG_LO +: TAG_BITS]);
        check_field("match_count", want.match_count, m_axis_tdata[OUT_CNT_LO +: MC_W]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAIL upcoming_event_sorted_query");
      $finish;
    end
  end

  initial begin
    request_t rows [$];
    request_t r;
    result_word_t fresh [$];
    result_word_t want;
    int unsigned adds_sent;
    int unsigned queries_sent;
    adds_sent = 0;
    queries_sent = 0;

    // empty table, limits, extremes of time and tag, equal starts, full table
    rows.push_back(query_row(stime_t'(0), 4'd8, 1'b1));
    rows.push_back(query_row(T_MIN, 4'd0, 1'b1));
    rows.push_back(add_row(T_MIN, T_MAX, 16'hFFFF, 1'b1, 1'b1));
    rows.push_back(query_row(T_MIN, 4'd0, 1'b1));
    rows.push_back(query_row(T_MAX, 4'd8, 1'b1));
    rows.push_back(query_row(T_MIN, 4'd8, 1'b0));
    rows.push_back(add_row(T_MAX, T_MIN, 16'h0000, 1'b1, 1'b1));
    rows.push_back(add_row(stime_t'(5), stime_t'(100), 16'h0001, 1'b1, 1'b1));
    rows.push_back(add_row(stime_t'(5), stime_t'(50), 16'h0002, 1'b1, 1'b1));
    rows.push_back(add_row(stime_t'(-3), stime_t'(20), 16'h0003, 1'b1, 1'b1));
    rows.push_back(query_row(T_MIN, 4'd15, 1'b0));
    rows.push_back(query_row(stime_t'(49), 4'd2, 1'b0));
    rows.push_back(query_row(stime_t'(50), 4'd8, 1'b0));
    rows.push_back(add_row(stime_t'(-3), stime_t'(-3), 16'h0004, 1'b1, 1'b1));
    rows.push_back(add_row(stime_t'(0), stime_t'(1), 16'h0005, 1'b1, 1'b1));
    rows.push_back(add_row(stime_t'(5), stime_t'(100), 16'h0006, 1'b1, 1'b1));
    rows.push_back(add_row(stime_t'(1), stime_t'(2), 16'h0007, 1'b1, 1'b0));
    rows.push_back(query_row(stime_t'(-4), 4'd8, 1'b0));
    rows.push_back(query_row(T_MIN, 4'd9, 1'b0));
    rows.push_back(query_row(stime_t'(19), 4'd1, 1'b0));
    rows.push_back(query_row(stime_t'(-1), 4'd12, 1'b0));
    rows.push_back(query_row(stime_t'(99), 4'd8, 1'b0));
    rows.push_back(query_row(T_MAX - 1, 4'd8, 1'b0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      drive_word(rows[i]);
      predict_request(rows[i], fresh);
      if (rows[i].typed) begin
        want = blank_word();
        want.accepted = rows[i].want_accept;
        pending_words.push_back(want);
      end else begin
        foreach (fresh[k]) pending_words.push_back(fresh[k]);
      end
      if (rows[i].req == REQ_ADD) adds_sent++;
      else queries_sent++;
    end

    // mostly queries, many aimed at the stored end times, with rejected adds mixed in
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 120 && n < 170);
      r.req = ($urandom_range(0, 99) < 15) ? REQ_ADD : REQ_QUERY;
      r.start_time = stime_t'({$urandom, $urandom});
      r.end_time = stime_t'({$urandom, $urandom});
      r.tag = tag_t'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: r.from_time = slot_end_q[$urandom_range(0, CAPACITY - 1)]
                                  - $urandom_range(0, 1);
        4, 5: r.from_time = stime_t'($signed($urandom_range(0, 400)) - 200);
        6, 7: r.from_time = stime_t'({$urandom, $urandom});
        8: r.from_time = T_MIN;
        default: r.from_time = T_MAX;
      endcase
      r.max_count = ($urandom_range(0, 99) < 70) ? count_t'($urandom_range(1, 8))
                                                 : count_t'($urandom_range(0, 15));
      r.typed = 1'b0;
      r.want_accept = 1'b0;
      drive_word(r);
      predict_request(r, fresh);
      foreach (fresh[k]) pending_words.push_back(fresh[k]);
      if (r.req == REQ_ADD) adds_sent++;
      else queries_sent++;
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      error_count++;
      $error("%0d expected words never arrived", pending_words.size());
    end

    $display("sent %0d adds (table filled, then rejected) and %0d queries", adds_sent,
             queries_sent);
    $display("checked %0d output words with %0d mismatches", words_checked, error_count);
    if (error_count == 0)
      $display("PASS upcoming_event_sorted_query");
    else
      $display("FAIL upcoming_event_sorted_query");
    $finish;
  end

endmodule
